// ===== src/dapid_pkg.sv =====
// Shared widths, stage numbering, register indexes and control types of the dual-axis PID loop.
package dapid_pkg;

   localparam int VAL_W     = 32;           // positions, errors and commands
   localparam int ERR_W     = VAL_W + 1;    // raw difference and error delta
   localparam int INTEG_W   = 48;           // integral of errors
   localparam int SUM_W     = INTEG_W + 1;  // integral before clamping
   localparam int GAIN_W    = 48;           // gain registers
   localparam int GAIN_FRAC = 32;           // fractional bits of the gains
   localparam int HALF_W    = GAIN_W / 2;   // width of one partial-product slice
   localparam int PE_W      = VAL_W + HALF_W + 1;
   localparam int PD_W      = ERR_W + HALF_W + 1;
   localparam int PIL_W     = 2 * HALF_W;
   localparam int PIH_W     = 2 * HALF_W + 1;
   localparam int ACC_W     = 98;           // exact sum of the three products
   localparam int Q_W       = ACC_W - GAIN_FRAC;

   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

   localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 48'd4294967296;
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 48'd43;
   localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 48'd51539607552;

   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP  = 2'd0,
      CSR_INTEG = 2'd1,
      CSR_DERIV = 2'd2
   } csr_index_type;

   // Pipeline stages, in the order a word passes through them.
   localparam int STG_IN     = 0;
   localparam int STG_TRACK  = 1;
   localparam int STG_PROD   = 2;
   localparam int STG_TERM   = 3;
   localparam int STG_PAIR   = 4;
   localparam int STG_OUT    = 5;
   localparam int NUM_STAGES = 6;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctl_type;

endpackage

// ===== src/dapid_if.sv =====
// Valid/ready channel interfaces for position samples and drive commands.
interface dapid_req_if;
   import dapid_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] ref_x;
   logic signed [VAL_W-1:0] ref_y;
   logic signed [VAL_W-1:0] meas_x;
   logic signed [VAL_W-1:0] meas_y;

   modport source (output valid, output ref_x, output ref_y, output meas_x, output meas_y,
                   input ready);
   modport sink (input valid, input ref_x, input ref_y, input meas_x, input meas_y,
                 output ready);
endinterface

interface dapid_rsp_if;
   import dapid_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] drive_x;
   logic signed [VAL_W-1:0] drive_y;
   logic                    clip_x;
   logic                    clip_y;

   modport source (output valid, output drive_x, output drive_y, output clip_x, output clip_y,
                   input ready);
   modport sink (input valid, input drive_x, input drive_y, input clip_x, input clip_y,
                 output ready);
endinterface

// ===== src/dual_axis_pid_position_loop.sv =====
// Top level of the dual-axis PID position loop: input stage, gain registers and pipeline control.
//
// Each word on the req channel is one sampling tick with the reference and measured
// positions of both axes; each yields exactly one rsp word with the saturated X and Y
// velocity commands and their clip flags. The block takes one word per clock cycle while rsp
// is ready; each word passes an input register, the error and integral update, and
// four stages that split each 48-bit gain product into 24-bit partial products and sum
// them before scaling and saturation. The pipeline stalls stage by stage, so empty stages
// still take words while a finished result waits. The user must write gain registers through
// the csr port only while the block is idle; the block itself does not enforce this.
module dual_axis_pid_position_loop (
   input  logic                                clock,
   input  logic                                reset,
   dapid_req_if.sink                           req,
   dapid_rsp_if.source                         rsp,
   input  logic                                csr_wr_en,
   input  logic [dapid_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dapid_pkg::GAIN_W-1:0]        csr_wdata
);
   import dapid_pkg::*;

   logic [GAIN_W-1:0]       prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic signed [VAL_W-1:0] ref_x_ff, ref_y_ff, meas_x_ff, meas_y_ff;

   logic [NUM_STAGES:0]     rdy;
   logic [NUM_STAGES-1:0]   feed;
   logic [NUM_STAGES-1:0]   v_in, v_ff;
   pipe_ctl_type            ctl;

   logic signed [VAL_W-1:0]   err_x, err_y;
   logic signed [INTEG_W-1:0] integ_x, integ_y;
   logic signed [ERR_W-1:0]   diff_x, diff_y;
   logic                      iclip_x, iclip_y;

   // A stage can take a word when it is empty or when its own word moves on.
   always_comb begin
      rdy[NUM_STAGES] = rsp.ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
      feed[STG_IN] = req.valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
         feed[k] = v_ff[k-1];
      end
      ctl.load = feed & rdy[NUM_STAGES-1:0];
      for (int k = 0; k < NUM_STAGES; k++) begin
         v_in[k] = rdy[k] ? feed[k] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= PROP_GAIN_RST;
         integ_gain_ff <= INTEG_GAIN_RST;
         deriv_gain_ff <= DERIV_GAIN_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PROP: begin
               prop_gain_ff <= csr_wdata;
            end
            CSR_INTEG: begin
               integ_gain_ff <= csr_wdata;
            end
            CSR_DERIV: begin
               deriv_gain_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[STG_IN]) begin
         ref_x_ff  <= req.ref_x;
         ref_y_ff  <= req.ref_y;
         meas_x_ff <= req.meas_x;
         meas_y_ff <= req.meas_y;
      end
   end

   dapid_track u_track_x (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .ref_pos  (ref_x_ff),
      .meas_pos (meas_x_ff),
      .err      (err_x),
      .integ    (integ_x),
      .diff     (diff_x),
      .iclip    (iclip_x)
   );

   dapid_track u_track_y (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .ref_pos  (ref_y_ff),
      .meas_pos (meas_y_ff),
      .err      (err_y),
      .integ    (integ_y),
      .diff     (diff_y),
      .iclip    (iclip_y)
   );

   dapid_prod u_prod_x (
      .clock      (clock),
      .ctl        (ctl),
      .err        (err_x),
      .integ      (integ_x),
      .diff       (diff_x),
      .iclip      (iclip_x),
      .prop_gain  (prop_gain_ff),
      .integ_gain (integ_gain_ff),
      .deriv_gain (deriv_gain_ff),
      .drive      (rsp.drive_x),
      .clip       (rsp.clip_x)
   );

   dapid_prod u_prod_y (
      .clock      (clock),
      .ctl        (ctl),
      .err        (err_y),
      .integ      (integ_y),
      .diff       (diff_y),
      .iclip      (iclip_y),
      .prop_gain  (prop_gain_ff),
      .integ_gain (integ_gain_ff),
      .deriv_gain (deriv_gain_ff),
      .drive      (rsp.drive_y),
      .clip       (rsp.clip_y)
   );

   assign req.ready = rdy[STG_IN];
   assign rsp.valid = v_ff[STG_OUT];

   // An empty output stage leaves a free slot all the way back to the input.
   a_free_slot_ready: assert property (@(posedge clock) disable iff (reset)
      !v_ff[STG_OUT] |-> req.ready)
      else $error("input not ready although the output stage is empty");

   // With every stage full and the output stalled, nothing may enter.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&v_ff) && !rsp.ready |-> !req.ready)
      else $error("word accepted into a full, stalled pipeline");

   // An accepted word always lands in the input stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> v_ff[STG_IN])
      else $error("accepted word lost at the input stage");

   // A taken result with nothing behind it leaves the output empty.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && !v_ff[STG_PAIR] |=> !rsp.valid)
      else $error("result repeated after it was taken");

endmodule

// ===== src/dapid_track.sv =====
// Per-axis error, saturating integral and error delta; holds the axis loop state.
module dapid_track (
   input  logic                                    clock,
   input  logic                                    reset,
   input  dapid_pkg::pipe_ctl_type                 ctl,
   input  logic signed [dapid_pkg::VAL_W-1:0]      ref_pos,
   input  logic signed [dapid_pkg::VAL_W-1:0]      meas_pos,
   output logic signed [dapid_pkg::VAL_W-1:0]      err,
   output logic signed [dapid_pkg::INTEG_W-1:0]    integ,
   output logic signed [dapid_pkg::ERR_W-1:0]      diff,
   output logic                                    iclip
);
   import dapid_pkg::*;

   logic signed [ERR_W-1:0]   raw_err;
   logic signed [SUM_W-1:0]   raw_sum;
   logic signed [VAL_W-1:0]   err_in, err_ff;
   logic signed [INTEG_W-1:0] integ_in, integ_ff;
   logic signed [ERR_W-1:0]   diff_in, diff_ff;
   logic                      iclip_in, iclip_ff;

   always_comb begin
      raw_err = ERR_W'(ref_pos) - ERR_W'(meas_pos);
      if (raw_err[ERR_W-1] != raw_err[ERR_W-2]) begin
         err_in = raw_err[ERR_W-1] ? VAL_MIN : VAL_MAX;
      end else begin
         err_in = raw_err[VAL_W-1:0];
      end

      raw_sum  = SUM_W'(integ_ff) + SUM_W'(err_in);
      iclip_in = raw_sum[SUM_W-1] != raw_sum[SUM_W-2];
      if (iclip_in) begin
         integ_in = raw_sum[SUM_W-1] ? INTEG_MIN : INTEG_MAX;
      end else begin
         integ_in = raw_sum[INTEG_W-1:0];
      end

      diff_in = ERR_W'(err_in) - ERR_W'(err_ff);
   end

   // The stage registers double as the loop state: the integral and the
   // previous error are exactly what the last accepted word left behind.
   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff   <= '0;
         integ_ff <= '0;
         diff_ff  <= '0;
         iclip_ff <= 1'b0;
      end else if (ctl.load[STG_TRACK]) begin
         err_ff   <= err_in;
         integ_ff <= integ_in;
         diff_ff  <= diff_in;
         iclip_ff <= iclip_in;
      end
   end

   assign err   = err_ff;
   assign integ = integ_ff;
   assign diff  = diff_ff;
   assign iclip = iclip_ff;

endmodule

// ===== src/dapid_prod.sv =====
// Per-axis gain products split into 24-bit slices, summed, scaled and saturated.
module dapid_prod (
   input  logic                                    clock,
   input  dapid_pkg::pipe_ctl_type                 ctl,
   input  logic signed [dapid_pkg::VAL_W-1:0]      err,
   input  logic signed [dapid_pkg::INTEG_W-1:0]    integ,
   input  logic signed [dapid_pkg::ERR_W-1:0]      diff,
   input  logic                                    iclip,
   input  logic [dapid_pkg::GAIN_W-1:0]            prop_gain,
   input  logic [dapid_pkg::GAIN_W-1:0]            integ_gain,
   input  logic [dapid_pkg::GAIN_W-1:0]            deriv_gain,
   output logic signed [dapid_pkg::VAL_W-1:0]      drive,
   output logic                                    clip
);
   import dapid_pkg::*;

   logic [HALF_W-1:0]        pg_lo, pg_hi, ig_lo, ig_hi, dg_lo, dg_hi;
   logic [HALF_W-1:0]        sum_lo;
   logic signed [HALF_W-1:0] sum_hi;

   logic signed [PE_W-1:0]  pe_lo_in, pe_hi_in, pe_lo_ff, pe_hi_ff;
   logic signed [PD_W-1:0]  pd_lo_in, pd_hi_in, pd_lo_ff, pd_hi_ff;
   logic [PIL_W-1:0]        pi_ll_in, pi_lh_in, pi_ll_ff, pi_lh_ff;
   logic signed [PIH_W-1:0] pi_hl_in, pi_hh_in, pi_hl_ff, pi_hh_ff;
   logic                    c2_ff, c3_ff, c4_ff;

   logic signed [ACC_W-1:0] te_in, td_in, ti_lo_in, ti_hi_in;
   logic signed [ACC_W-1:0] te_ff, td_ff, ti_lo_ff, ti_hi_ff;
   logic signed [ACC_W-1:0] pair_a_in, pair_b_in, pair_a_ff, pair_b_ff;

   logic signed [ACC_W-1:0] acc;
   logic [Q_W-1:0]          quo;
   logic                    ovf;
   logic signed [VAL_W-1:0] drive_in, drive_ff;
   logic                    clip_in, clip_ff;

   assign pg_lo  = prop_gain[HALF_W-1:0];
   assign pg_hi  = prop_gain[GAIN_W-1:HALF_W];
   assign ig_lo  = integ_gain[HALF_W-1:0];
   assign ig_hi  = integ_gain[GAIN_W-1:HALF_W];
   assign dg_lo  = deriv_gain[HALF_W-1:0];
   assign dg_hi  = deriv_gain[GAIN_W-1:HALF_W];
   assign sum_lo = integ[HALF_W-1:0];
   assign sum_hi = integ[INTEG_W-1:HALF_W];

   // Partial products: each gain is split into two unsigned 24-bit slices,
   // and the integral into a signed upper and an unsigned lower slice.
   always_comb begin
      pe_lo_in = err * $signed({1'b0, pg_lo});
      pe_hi_in = err * $signed({1'b0, pg_hi});
      pd_lo_in = diff * $signed({1'b0, dg_lo});
      pd_hi_in = diff * $signed({1'b0, dg_hi});
      pi_ll_in = sum_lo * ig_lo;
      pi_lh_in = sum_lo * ig_hi;
      pi_hl_in = sum_hi * $signed({1'b0, ig_lo});
      pi_hh_in = sum_hi * $signed({1'b0, ig_hi});
   end

   always_comb begin
      te_in    = ACC_W'(pe_lo_ff) + (ACC_W'(pe_hi_ff) <<< HALF_W);
      td_in    = ACC_W'(pd_lo_ff) + (ACC_W'(pd_hi_ff) <<< HALF_W);
      ti_lo_in = ACC_W'(pi_ll_ff) + (ACC_W'(pi_lh_ff) << HALF_W);
      ti_hi_in = (ACC_W'(pi_hl_ff) <<< HALF_W) + (ACC_W'(pi_hh_ff) <<< (2 * HALF_W));
   end

   assign pair_a_in = te_ff + td_ff;
   assign pair_b_in = ti_lo_ff + ti_hi_ff;

   // Dropping the low gain fraction bits is an arithmetic shift, so the
   // result rounds toward minus infinity before the 32-bit clamp.
   always_comb begin
      acc     = pair_a_ff + pair_b_ff;
      quo     = acc[ACC_W-1:GAIN_FRAC];
      ovf     = !(&quo[Q_W-1:VAL_W-1]) && (|quo[Q_W-1:VAL_W-1]);
      clip_in = c4_ff | ovf;
      if (ovf) begin
         drive_in = quo[Q_W-1] ? VAL_MIN : VAL_MAX;
      end else begin
         drive_in = quo[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[STG_PROD]) begin
         pe_lo_ff <= pe_lo_in;
         pe_hi_ff <= pe_hi_in;
         pd_lo_ff <= pd_lo_in;
         pd_hi_ff <= pd_hi_in;
         pi_ll_ff <= pi_ll_in;
         pi_lh_ff <= pi_lh_in;
         pi_hl_ff <= pi_hl_in;
         pi_hh_ff <= pi_hh_in;
         c2_ff    <= iclip;
      end
      if (ctl.load[STG_TERM]) begin
         te_ff    <= te_in;
         td_ff    <= td_in;
         ti_lo_ff <= ti_lo_in;
         ti_hi_ff <= ti_hi_in;
         c3_ff    <= c2_ff;
      end
      if (ctl.load[STG_PAIR]) begin
         pair_a_ff <= pair_a_in;
         pair_b_ff <= pair_b_in;
         c4_ff     <= c3_ff;
      end
      if (ctl.load[STG_OUT]) begin
         drive_ff <= drive_in;
         clip_ff  <= clip_in;
      end
   end

   assign drive = drive_ff;
   assign clip  = clip_ff;

endmodule

// ===== bench/dual_axis_pid_position_loop_tb.sv =====
// Self-checking bench for the dual-axis PID loop: random and directed samples against a predictor.
`timescale 1ns / 1ps

module dual_axis_pid_position_loop_tb;
   import dapid_pkg::*;

   typedef struct packed {
      logic signed [VAL_W-1:0] ref_x;
      logic signed [VAL_W-1:0] ref_y;
      logic signed [VAL_W-1:0] meas_x;
      logic signed [VAL_W-1:0] meas_y;
   } position_sample_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] drive_x;
      logic signed [VAL_W-1:0] drive_y;
      logic                    clip_x;
      logic                    clip_y;
   } drive_word_type;

   class drive_scoreboard_type;
      logic [GAIN_W-1:0]         kp;
      logic [GAIN_W-1:0]         ki;
      logic [GAIN_W-1:0]         kd;
      logic signed [INTEG_W-1:0] integ_acc [2];
      logic signed [VAL_W-1:0]   last_err [2];
      drive_word_type            pending_drives [$];
      int unsigned               mismatches;

      function new();
         kp = PROP_GAIN_RST;
         ki = INTEG_GAIN_RST;
         kd = DERIV_GAIN_RST;
         for (int a = 0; a < 2; a++) begin
            integ_acc[a] = '0;
            last_err[a]  = '0;
         end
         mismatches = 0;
      endfunction

      function void write_gain(logic [CSR_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
         case (idx)
            CSR_PROP:  kp = val;
            CSR_INTEG: ki = val;
            CSR_DERIV: kd = val;
            default: ;
         endcase
      endfunction

      // One axis of one tick; all sums are carried exactly at 128 bits.
      function void axis_step(input int a, input logic signed [VAL_W-1:0] r,
                              input logic signed [VAL_W-1:0] m,
                              output logic signed [VAL_W-1:0] drv, output logic clip);
         logic signed [127:0] err, sum, delta, acc, q, gp, gi, gd;
         clip = 1'b0;
         err = r - m;
         if (err > VAL_MAX) err = VAL_MAX;
         if (err < VAL_MIN) err = VAL_MIN;
         sum = integ_acc[a] + err;
         if (sum > INTEG_MAX) begin
            sum  = INTEG_MAX;
            clip = 1'b1;
         end
         if (sum < INTEG_MIN) begin
            sum  = INTEG_MIN;
            clip = 1'b1;
         end
         delta = err - last_err[a];
         gp = {80'd0, kp};
         gi = {80'd0, ki};
         gd = {80'd0, kd};
         acc = err * gp + sum * gi + delta * gd;
         q = acc >>> GAIN_FRAC;
         if (q > VAL_MAX) begin
            drv  = VAL_MAX;
            clip = 1'b1;
         end else if (q < VAL_MIN) begin
            drv  = VAL_MIN;
            clip = 1'b1;
         end else begin
            drv = q[VAL_W-1:0];
         end
         integ_acc[a] = sum[INTEG_W-1:0];
         last_err[a]  = err[VAL_W-1:0];
      endfunction

      function void note_sample(position_sample_type s);
         drive_word_type w;
         axis_step(0, s.ref_x, s.meas_x, w.drive_x, w.clip_x);
         axis_step(1, s.ref_y, s.meas_y, w.drive_y, w.clip_y);
         pending_drives.push_back(w);
      endfunction

      function void report(string what, drive_word_type want, drive_word_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t %s: expected x=%0d y=%0d clip=%b%b, got x=%0d y=%0d clip=%b%b",
                     $realtime, what, want.drive_x, want.drive_y, want.clip_x, want.clip_y,
                     got.drive_x, got.drive_y, got.clip_x, got.clip_y);
      endfunction

      function void check_drive(drive_word_type got);
         drive_word_type want;
         if (pending_drives.size() == 0) begin
            report("unexpected drive word", '0, got);
            return;
         end
         want = pending_drives.pop_front();
         if (got.drive_x !== want.drive_x || got.drive_y !== want.drive_y ||
             got.clip_x !== want.clip_x || got.clip_y !== want.clip_y)
            report("drive mismatch", want, got);
      endfunction
   endclass

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;  // no register behind it
   localparam logic [GAIN_W-1:0]    GAIN_MAX  = {GAIN_W{1'b1}};

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [GAIN_W-1:0]    csr_wdata;
   int unsigned          send_idle_pct;
   int unsigned          rcv_stall_pct;
   drive_scoreboard_type sb;

   dapid_req_if req_ch ();
   dapid_rsp_if rsp_ch ();

   dual_axis_pid_position_loop u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[dual_axis_pid_position_loop] ERROR");
      $finish;
   end

   // The receiver decides its ready at each falling edge.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = !(rcv_stall_pct != 0 && $urandom_range(99) < rcv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_drive({rsp_ch.drive_x, rsp_ch.drive_y, rsp_ch.clip_x, rsp_ch.clip_y});
   end

   // Called and returns at a falling edge.
   task automatic push_sample(input logic signed [VAL_W-1:0] rx, input logic signed [VAL_W-1:0] ry,
                              input logic signed [VAL_W-1:0] mx, input logic signed [VAL_W-1:0] my);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid  = 1'b1;
      req_ch.ref_x  = rx;
      req_ch.ref_y  = ry;
      req_ch.meas_x = mx;
      req_ch.meas_y = my;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_sample({rx, ry, mx, my});
      @(negedge clock);
   endtask

   task automatic write_gain(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      sb.write_gain(idx, val);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Pause the sender until every expected word is back, then let the pipe settle.
   task automatic wait_for_drives();
      req_ch.valid = 1'b0;
      while (sb.pending_drives.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_gain_set(input int setting);
      logic [GAIN_W-1:0] p, i, d;
      case (setting % 8)
         0: begin
            p = PROP_GAIN_RST;  i = INTEG_GAIN_RST;  d = DERIV_GAIN_RST;
         end
         1: begin
            p = GAIN_MAX;  i = GAIN_MAX;  d = GAIN_MAX;
         end
         2: begin
            p = '0;  i = '0;  d = '0;
         end
         3, 6: begin
            p = GAIN_W'({$urandom_range(0, 3), $urandom});
            i = GAIN_W'($urandom_range(0, 4095));
            d = GAIN_W'({$urandom_range(0, 15), $urandom});
         end
         5: begin
            p = '0;  i = GAIN_MAX;  d = '0;
         end
         7: begin
            p = GAIN_W'({$urandom, $urandom} >> $urandom_range(0, 47));
            i = GAIN_W'({$urandom, $urandom} >> $urandom_range(0, 47));
            d = GAIN_W'({$urandom, $urandom} >> $urandom_range(0, 47));
         end
         default: begin
            p = GAIN_W'({$urandom, $urandom});
            i = GAIN_W'({$urandom, $urandom});
            d = GAIN_W'({$urandom, $urandom});
         end
      endcase
      write_gain(CSR_PROP, p);
      write_gain(CSR_INTEG, i);
      write_gain(CSR_DERIV, d);
      write_gain(CSR_SPARE, GAIN_W'({$urandom, $urandom}));
   endtask

   // Mostly a measurement that tracks its reference, with some noise and some extremes.
   function automatic void random_axis(output logic signed [VAL_W-1:0] r,
                                       output logic signed [VAL_W-1:0] m);
      int unsigned pick;
      logic [VAL_W-1:0] delta;
      pick = $urandom_range(99);
      r = $urandom;
      if (pick < 70) begin
         delta = $urandom & ((32'd1 << $urandom_range(0, 24)) - 32'd1);
         m = $urandom_range(1) ? r + delta : r - delta;
      end else if (pick < 90) begin
         m = $urandom;
      end else begin
         case ($urandom_range(3))
            0: r = VAL_MAX;
            1: r = VAL_MIN;
            2: r = '0;
            default: r = '1;
         endcase
         case ($urandom_range(3))
            0: m = VAL_MAX;
            1: m = VAL_MIN;
            2: m = '0;
            default: m = '1;
         endcase
      end
   endfunction

   initial begin
      logic signed [VAL_W-1:0] rx, ry, mx, my;
      sb = new();
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      req_ch.valid  = 1'b0;
      req_ch.ref_x  = '0;
      req_ch.ref_y  = '0;
      req_ch.meas_x = '0;
      req_ch.meas_y = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed samples at the reset gains: field extremes, error overflow both ways,
      // bit patterns, and a repeated sample so the derivative term drops to zero.
      push_sample(0, 0, 0, 0);
      push_sample(VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX);
      push_sample(VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN);
      push_sample(VAL_MAX, 0, 0, VAL_MIN);
      push_sample(0, VAL_MIN, VAL_MAX, 0);
      push_sample(32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555);
      push_sample(-1, -1, 0, 0);
      push_sample(0, 0, -1, -1);
      push_sample(65536, -65536, 0, 0);
      push_sample(100, 200, 99, 201);
      push_sample(100, 200, 99, 201);
      push_sample(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
      push_sample(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);
      push_sample(-65536, 65536, 65536, -65536);
      wait_for_drives();

      for (int ph = 0; ph < 8; ph++) begin
         load_gain_set(ph);
         case (ph % 4)
            0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; rcv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rcv_stall_pct = 73; end
            default: begin send_idle_pct = 16; rcv_stall_pct = 16; end
         endcase
         repeat (120) begin
            random_axis(rx, mx);
            random_axis(ry, my);
            push_sample(rx, ry, mx, my);
         end
         wait_for_drives();
      end

      if (sb.mismatches == 0 && sb.pending_drives.size() == 0)
         $display("[dual_axis_pid_position_loop] OK");
      else
         $display("[dual_axis_pid_position_loop] ERROR");
      $finish;
   end

endmodule
